// ----- rtl/core/hav_pkg.sv -----
// package for the haversine distance pipeline: constants, types, atan table
package hav_pkg;

	localparam int ANG_W = 34;   // Q3.29 plus headroom
	localparam int CW = 36;      // cordic datapath width
	localparam longint Q30_ONE = 64'd1073741824;
	localparam longint PI_Q29 = 64'd1686629713;
	localparam longint HALF_PI_Q29 = 64'd843314857;
	localparam longint CORDIC_K = 64'd652032874;
	localparam longint DIST_MAX = 64'd20015087;
	localparam longint TWO_R = 64'd12742000;

	typedef logic signed [CW-1:0] cw_t;

	// truncated atan(2^-i) in Q1.30, zero beyond index 30
	function automatic cw_t atan_at(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
			3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
			6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
			9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
			18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
			21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
			24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
			27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
			30: v = 32'h00000001;
			default: v = 32'h0;
		endcase
		return cw_t'({4'b0, v});
	endfunction

endpackage

// ----- rtl/core/haversine_distance.sv -----
// haversine great-circle distance: one position pair in and one distance out per clock
// latitude/longitude in 1e-7 degree, result in whole metres
// pipeline order: angle conversion, range reduction, the pipelined rotation cordics,
// product stages, per-bit square-root stages, vectoring cordic, then distance stages
// throughput: one word per cycle; a stall on the output freezes the whole pipe
// arst_n clears all valid bits; data registers are not reset
module haversine_distance import hav_pkg::*; #(
	parameter int TRIG_ITERATIONS = 30
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// start_latitude[30:0], start_longitude[62:31], end_latitude[93:63],
	// end_longitude[125:94], zero pad [127:126]
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// distance_metres[24:0], zero pad [31:25]
	output logic [31:0]  m_tdata
);
	localparam int LAT = 4 + 1 + TRIG_ITERATIONS + 4 + 32 + TRIG_ITERATIONS + 3;

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// valid shift line travels with the data
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], s_tvalid};
	end
	assign m_tvalid = vld_q[LAT-1];

	logic signed [32:0] lat1, lon1, lat2, lon2;
	assign lat1 = 33'(signed'(s_tdata[30:0]));
	assign lon1 = 33'(signed'(s_tdata[62:31]));
	assign lat2 = 33'(signed'(s_tdata[93:63]));
	assign lon2 = 33'(signed'(s_tdata[125:94]));

	// angle conversion
	cw_t a_dlat, a_dlon, a_lat1, a_lat2;
	hav_torad #(.HALF(1'b1)) u_cv0 (.clk, .en, .v(lat2 - lat1), .ang(a_dlat));
	hav_torad #(.HALF(1'b1)) u_cv1 (.clk, .en, .v(lon2 - lon1), .ang(a_dlon));
	hav_torad #(.HALF(1'b0)) u_cv2 (.clk, .en, .v(lat1), .ang(a_lat1));
	hav_torad #(.HALF(1'b0)) u_cv3 (.clk, .en, .v(lat2), .ang(a_lat2));

	// range reduction, doubles to Q1.30
	cw_t  z_r [4];
	logic flip_r [4];
	cw_t  ang_in [4];
	assign ang_in[0] = a_dlat;
	assign ang_in[1] = a_dlon;
	assign ang_in[2] = a_lat1;
	assign ang_in[3] = a_lat2;
	for (genvar k = 0; k < 4; k++) begin : g_rr
		always_ff @(posedge clk) begin
			if (en) begin
				if (ang_in[k] > cw_t'(HALF_PI_Q29)) begin
					z_r[k] <= (cw_t'(PI_Q29) - ang_in[k]) <<< 1;
					flip_r[k] <= 1'b1;
				end else if (ang_in[k] < -cw_t'(HALF_PI_Q29)) begin
					z_r[k] <= (-cw_t'(PI_Q29) - ang_in[k]) <<< 1;
					flip_r[k] <= 1'b1;
				end else begin
					z_r[k] <= ang_in[k] <<< 1;
					flip_r[k] <= 1'b0;
				end
			end
		end
	end

	// four rotation cordics and their flip flags
	cw_t cx [4];
	cw_t cy [4];
	cw_t cz [4];
	logic [TRIG_ITERATIONS-1:0] flip_d [4];
	for (genvar k = 0; k < 4; k++) begin : g_sc
		hav_cordic #(.ITER(TRIG_ITERATIONS), .VECTOR(1'b0)) u_sc (
			.clk, .arst_n, .en,
			.x_in(cw_t'(CORDIC_K)), .y_in('0), .z_in(z_r[k]),
			.x_out(cx[k]), .y_out(cy[k]), .z_out(cz[k])
		);
		always_ff @(posedge clk) begin
			if (en) flip_d[k] <= {flip_d[k][TRIG_ITERATIONS-2:0], flip_r[k]};
		end
	end

	function automatic cw_t clampu(input cw_t v);
		if (v > cw_t'(Q30_ONE)) return cw_t'(Q30_ONE);
		if (v < -cw_t'(Q30_ONE)) return -cw_t'(Q30_ONE);
		return v;
	endfunction

	// stage p1: clamp, and negate the flipped cosines
	cw_t s1_p1, s2_p1, c1_p1, c2_p1;
	always_ff @(posedge clk) begin
		if (en) begin
			s1_p1 <= clampu(cy[0]);
			s2_p1 <= clampu(cy[1]);
			c1_p1 <= flip_d[2][TRIG_ITERATIONS-1] ? -clampu(cx[2]) : clampu(cx[2]);
			c2_p1 <= flip_d[3][TRIG_ITERATIONS-1] ? -clampu(cx[3]) : clampu(cx[3]);
		end
	end

	// stage p2: squares and cosine product
	logic signed [63:0] ss1_p2, ss2_p2, cc_p2;
	always_ff @(posedge clk) begin
		if (en) begin
			ss1_p2 <= 64'(s1_p1) * 64'(s1_p1);
			ss2_p2 <= 64'(s2_p1) * 64'(s2_p1);
			cc_p2  <= 64'(c1_p1) * 64'(c2_p1);
		end
	end

	// stage p3: second product
	logic signed [63:0] t_p3;
	cw_t h1_p3;
	always_ff @(posedge clk) begin
		if (en) begin
			h1_p3 <= cw_t'(ss1_p2 >>> 30);
			t_p3 <= 64'(cw_t'(cc_p2 >>> 30)) * 64'(cw_t'(ss2_p2 >>> 30));
		end
	end

	// stage p4: sum and clamp a, form root operands
	cw_t asum;
	logic [61:0] ra_p4, rb_p4;
	assign asum = h1_p3 + cw_t'(t_p3 >>> 30);
	always_ff @(posedge clk) begin
		logic [30:0] a;
		if (asum < 0) a = '0;
		else if (asum > cw_t'(Q30_ONE)) a = 31'(Q30_ONE);
		else a = 31'(asum);
		if (en) begin
			ra_p4 <= {a, 31'b0} >> 1;
			rb_p4 <= {31'(Q30_ONE) - a, 31'b0} >> 1;
		end
	end

	// floor square roots, one result bit per stage
	logic [63:0] rn_a [33];
	logic [63:0] rr_a [33];
	logic [63:0] rn_b [33];
	logic [63:0] rr_b [33];
	assign rn_a[0] = {2'b0, ra_p4};
	assign rr_a[0] = '0;
	assign rn_b[0] = {2'b0, rb_p4};
	assign rr_b[0] = '0;
	for (genvar i = 0; i < 32; i++) begin : g_sq
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (rn_a[i] >= rr_a[i] + BIT) begin
					rn_a[i+1] <= rn_a[i] - (rr_a[i] + BIT);
					rr_a[i+1] <= (rr_a[i] >> 1) + BIT;
				end else begin
					rn_a[i+1] <= rn_a[i];
					rr_a[i+1] <= rr_a[i] >> 1;
				end
				if (rn_b[i] >= rr_b[i] + BIT) begin
					rn_b[i+1] <= rn_b[i] - (rr_b[i] + BIT);
					rr_b[i+1] <= (rr_b[i] >> 1) + BIT;
				end else begin
					rn_b[i+1] <= rn_b[i];
					rr_b[i+1] <= rr_b[i] >> 1;
				end
			end
		end
	end

	// atan2 by vectoring
	cw_t vx, vy, vz;
	hav_cordic #(.ITER(TRIG_ITERATIONS), .VECTOR(1'b1)) u_at (
		.clk, .arst_n, .en,
		.x_in(cw_t'(rr_b[32])), .y_in(cw_t'(rr_a[32])), .z_in('0),
		.x_out(vx), .y_out(vy), .z_out(vz)
	);

	// distance: clamp, multiply and shift, saturate
	logic [31:0] z_q1;
	logic [63:0] d_q2;
	logic [24:0] d_q3;
	always_ff @(posedge clk) begin
		if (en) begin
			z_q1 <= (vz < 0) ? '0 : 32'(vz);
			d_q2 <= (64'(z_q1) * 64'(TWO_R)) >> 30;
			d_q3 <= (d_q2 > 64'(DIST_MAX)) ? 25'(DIST_MAX) : 25'(d_q2);
		end
	end
	assign m_tdata = {7'b0, d_q3};

	logic unused;
	assign unused = ^cz[0] ^ ^cz[1] ^ ^cz[2] ^ ^cz[3] ^ ^cx[0] ^ ^cx[1] ^ ^cy[2] ^ ^cy[3]
		^ ^vx ^ ^vy ^ ^rn_a[32] ^ ^rn_b[32] ^ ^s_tdata[127:126];

endmodule

// ----- rtl/core/hav_cordic.sv -----
// pipelined cordic: rotation mode for sine/cosine, vectoring mode for atan2
module hav_cordic import hav_pkg::*; #(
	parameter int ITER = 30,
	parameter bit VECTOR = 1'b0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  cw_t  x_in,
	input  cw_t  y_in,
	input  cw_t  z_in,
	output cw_t  x_out,
	output cw_t  y_out,
	output cw_t  z_out
);

	cw_t x_s [ITER+1];
	cw_t y_s [ITER+1];
	cw_t z_s [ITER+1];

	assign x_s[0] = x_in;
	assign y_s[0] = y_in;
	assign z_s[0] = z_in;

	// one micro-rotation per stage
	for (genvar i = 0; i < ITER; i++) begin : g_it
		logic dn;
		assign dn = VECTOR ? (y_s[i] > 0) : (z_s[i] >= 0);
		always_ff @(posedge clk) begin
			if (en) begin
				if (VECTOR ? dn : dn) begin
					if (VECTOR) begin
						x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] + atan_at(i);
					end else begin
						x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] - atan_at(i);
					end
				end else begin
					if (VECTOR) begin
						x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] - atan_at(i);
					end else begin
						x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] + atan_at(i);
					end
				end
			end
		end
	end

	assign x_out = x_s[ITER];
	assign y_out = y_s[ITER];
	assign z_out = z_s[ITER];

	logic unused_rst;
	assign unused_rst = arst_n;

endmodule

// ----- rtl/core/hav_torad.sv -----
// degree-to-radian conversion, pipelined: v * 2^29 * pi / 180e7, truncated toward zero
module hav_torad import hav_pkg::*; #(
	parameter bit HALF = 1'b0
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [32:0]      v,
	output cw_t                     ang
);
	// q = floor(mag * 31415926 * 2^29 / D), D = 18e15 (or 36e15 for half)
	// computed as floor(mag * M / 2^S), M the scaled reciprocal rounded up
	localparam longint unsigned DEN = HALF ? 64'd36000000000000000 : 64'd18000000000000000;
	// the reduced divisor is below 2^38 and mag below 2^32, so with S = 72 the
	// rounding error of M stays under 2^-40 and the floor is exact
	localparam int SH = 72;
	localparam logic [71:0] RECIP = 72'(((128'd31415926 << (29 + SH)) / 128'(DEN)) + 128'd1);

	logic        neg_s1, neg_s2, neg_s3;
	logic [32:0] mag_s1;
	logic [63:0] prod_lo_s2, prod_hi_s2, prod_top_s2;
	logic [127:0] q_s3;

	// stage 1: magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= v[32];
			mag_s1 <= v[32] ? 33'(-v) : 33'(v);
		end
	end

	// stage 2: three partial products of mag times reciprocal
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= neg_s1;
			prod_lo_s2 <= 64'(mag_s1) * 64'(RECIP[31:0]);
			prod_hi_s2 <= 64'(mag_s1) * 64'(RECIP[63:32]);
			prod_top_s2 <= 64'(mag_s1) * 64'(RECIP[71:64]);
		end
	end

	// stage 3: combine partial products
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3 <= neg_s2;
			q_s3 <= ({64'b0, prod_top_s2} << 64) + ({64'b0, prod_hi_s2} << 32)
				+ {64'b0, prod_lo_s2};
		end
	end

	// stage 4: shift and restore sign
	always_ff @(posedge clk) begin
		if (en) ang <= neg_s3 ? -cw_t'(q_s3 >> SH) : cw_t'(q_s3 >> SH);
	end

endmodule
